### src/coverage_area_assigner_defines.svh
// Assertion macros for the coverage area assigner.
// Users supply clk_i and rst_ni in scope; no other dependencies.
`ifndef COVERAGE_AREA_ASSIGNER_DEFINES_SVH
`define COVERAGE_AREA_ASSIGNER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define CAA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define CAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/caa_pkg.sv
// Shared types and constants of the coverage area assigner.
// No dependencies; used by the channel interfaces and the top level.
package caa_pkg;

  // Field widths
  localparam int unsigned COLS_W     = 7;
  localparam int unsigned ROWS_W     = 7;
  localparam int unsigned SPACING_W  = 10;
  localparam int unsigned GPA_W      = 8;
  localparam int unsigned ROBOT_W    = 8;
  localparam int unsigned COV_W      = 8;
  localparam int unsigned ID_W       = 7;
  localparam int unsigned CTR_W      = 16;
  localparam int unsigned TOT_W      = 14;
  localparam int unsigned DEP_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Default sizes
  localparam int unsigned DEF_MAX_AREAS  = 64;
  localparam int unsigned DEF_MAX_ROBOTS = 16;

  // Register reset values
  localparam logic [COLS_W-1:0]    RST_COLUMNS = 7'd4;
  localparam logic [ROWS_W-1:0]    RST_ROWS    = 7'd4;
  localparam logic [SPACING_W-1:0] RST_SPACING = 10'd100;
  localparam logic [GPA_W-1:0]     RST_GRIDS   = 8'd4;

  // Input word kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_SPACING = 2'd2,
    CFG_GRIDS   = 2'd3
  } cfg_idx_e;

  // One result word
  typedef struct packed {
    logic [ROBOT_W-1:0] target_robot;
    logic               assigned;
    logic [ID_W-1:0]    area_id;
    logic [CTR_W-1:0]   centre_x;
    logic [CTR_W-1:0]   centre_y;
    logic [TOT_W-1:0]   covered_total;
    logic [TOT_W-1:0]   grid_total;
    logic [DEP_W-1:0]   robots_deployed;
    logic               last;
  } result_t;

endpackage

### src/caa_in_if.sv
// Input channel of the coverage area assigner: valid/ready plus request fields.
// Depends on caa_pkg for field widths.
interface caa_in_if import caa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ROBOT_W-1:0] robot_no;
  logic [COV_W-1:0]   grids_done;

  modport source (output valid, kind, robot_no, grids_done, input ready);
  modport sink   (input valid, kind, robot_no, grids_done, output ready);
endinterface

### src/caa_out_if.sv
// Output channel of the coverage area assigner: valid/ready plus result fields.
// Depends on caa_pkg for field widths.
interface caa_out_if import caa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROBOT_W-1:0] target_robot;
  logic               assigned;
  logic [ID_W-1:0]    area_id;
  logic [CTR_W-1:0]   centre_x;
  logic [CTR_W-1:0]   centre_y;
  logic [TOT_W-1:0]   covered_total;
  logic [TOT_W-1:0]   grid_total;
  logic [DEP_W-1:0]   robots_deployed;
  logic               last;

  modport source (output valid, target_robot, assigned, area_id, centre_x, centre_y,
                  covered_total, grid_total, robots_deployed, last, input ready);
  modport sink   (input valid, target_robot, assigned, area_id, centre_x, centre_y,
                  covered_total, grid_total, robots_deployed, last, output ready);
endinterface

### src/caa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module caa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

### src/coverage_area_assigner.sv
// Coverage area assigner: area coverage table, robot assignment and deployment.
// Depends on caa_pkg, caa_in_if, caa_out_if, caa_ram and the assertion macros.
//
// Usage
//   in_i  : one word per request. kind selects start of deployment or a robot
//           coverage report (robot_no, grids_done).
//   out_o : result words. A start gives one or two words (robot 0, then robot 1
//           when more than one area exists); a report gives one word. The
//           final word of a request carries last = 1.
//   cfg_* : register writes (columns, rows, spacing, grids per area), to be
//           made only while the block is idle; the block itself leaves this to the user.
// Timing
//   A request passes the area count, grid total, table update, a scan of the n
//   entries (n being columns * rows, capped at MAX_AREAS) and the two centre
//   coordinates; a start repeats the centre steps for its second word. The scan
//   makes one RAM read a cycle through the single read port; the shared multiplier
//   serves the area count, grid total and the two centre coordinates.
//   in_i.ready is high only between requests; one request is handled at a time.
// Reset clears the coverage table (per-entry valid bits), all robot
// assignments, the deployment count and loads the register defaults. A
// stalled receiver holds the output word; the next request is accepted
// meanwhile and waits at its first word until the output register frees.
`include "coverage_area_assigner_defines.svh"

module coverage_area_assigner import caa_pkg::*; #(
  parameter int unsigned MAX_AREAS       = DEF_MAX_AREAS,
  parameter int unsigned MAX_ROBOT_COUNT = DEF_MAX_ROBOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  caa_in_if.sink                in_i,
  caa_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MAX_AREAS + 1);
  localparam int unsigned IW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int unsigned RW = $clog2(MAX_ROBOT_COUNT);
  localparam int unsigned MW = (AW > 8) ? AW : 8;
  localparam int unsigned PW = MW + SPACING_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_GRID,
    ST_UPDATE,
    ST_SCAN,
    ST_CX,
    ST_CY
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [COLS_W-1:0]    cols_q, cols_d;
  logic [ROWS_W-1:0]    rows_q, rows_d;
  logic [SPACING_W-1:0] spacing_q, spacing_d;
  logic [GPA_W-1:0]     gpa_q, gpa_d;

  // request word
  logic               kind_q, kind_d;
  logic [ROBOT_W-1:0] robot_q, robot_d;
  logic [COV_W-1:0]   covered_q, covered_d;

  // sequencer working registers
  logic [AW-1:0]     n_q, n_d;
  logic [TOT_W-1:0]  grid_q, grid_d;
  logic [AW-1:0]     s_q, s_d;
  logic [TOT_W-1:0]  sum_q, sum_d;
  logic [COLS_W-1:0] col_q, col_d;
  logic [IW-1:0]     row_q, row_d;
  logic              found_q, found_d;
  logic [IW-1:0]     fidx_q, fidx_d;
  logic [COLS_W-1:0] fcol_q, fcol_d;
  logic [IW-1:0]     frow_q, frow_d;
  logic [COLS_W-1:0] lcol_q, lcol_d;
  logic [IW-1:0]     lrow_q, lrow_d;
  logic              res_q, res_d;
  logic [CTR_W-1:0]  cx_q, cx_d;
  logic [DEP_W-1:0]  dep_q, dep_d;
  logic              rd_vld_q, rd_vld_d;

  // output register
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  // state tables
  logic [MAX_AREAS-1:0] cov_vld_q;
  logic [AW-1:0]        robot_area_q [MAX_ROBOT_COUNT];

  // shared multiplier
  logic [MW-1:0]        mul_a;
  logic [SPACING_W-1:0] mul_b;
  logic [PW-1:0]        mul_p;

  // RAM port
  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [COV_W-1:0] ram_rdata;

  // table write controls
  logic          ra0_we, ra1_we, rar_we;
  logic [AW-1:0] rar_wdata;

  // helpers
  logic              robot_ok;
  logic [AW-1:0]     ra_cur;
  logic [COV_W-1:0]  scan_val;
  logic              out_free;
  logic [ROBOT_W-1:0] sel_robot;
  logic              sel_ok;
  logic [IW-1:0]     sel_idx;
  logic [COLS_W-1:0] sel_col;
  logic [IW-1:0]     sel_row;
  logic              sel_last;
  logic              out_no_area;
  logic              out_pair_head;

  assign mul_p    = PW'(mul_a) * PW'(mul_b);
  assign robot_ok = {24'd0, robot_q} < 32'(MAX_ROBOT_COUNT);
  assign ra_cur   = robot_area_q[robot_q[RW-1:0]];
  assign scan_val = rd_vld_q ? ram_rdata : '0;
  assign out_free = !out_valid_q || out_o.ready;

  caa_ram #(
    .WIDTH (COV_W),
    .DEPTH (MAX_AREAS)
  ) u_cov_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (covered_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result selection: which robot, area and position the next word describes
  always_comb begin
    if (kind_q == KIND_START) begin
      if (!res_q) begin
        sel_robot = '0;
        sel_ok    = (n_q != '0);
        sel_idx   = '0;
        sel_col   = '0;
        sel_row   = '0;
        sel_last  = !(n_q > AW'(1));
      end else begin
        sel_robot = ROBOT_W'(1);
        sel_ok    = 1'b1;
        sel_idx   = IW'(n_q - AW'(1));
        sel_col   = lcol_q;
        sel_row   = lrow_q;
        sel_last  = 1'b1;
      end
    end else begin
      sel_robot = robot_q;
      sel_ok    = found_q;
      sel_idx   = fidx_q;
      sel_col   = fcol_q;
      sel_row   = frow_q;
      sel_last  = 1'b1;
    end
  end

  // sequencer next-state logic
  always_comb begin
    state_d     = state_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    spacing_d   = spacing_q;
    gpa_d       = gpa_q;
    kind_d      = kind_q;
    robot_d     = robot_q;
    covered_d   = covered_q;
    n_d         = n_q;
    grid_d      = grid_q;
    s_d         = s_q;
    sum_d       = sum_q;
    col_d       = col_q;
    row_d       = row_q;
    found_d     = found_q;
    fidx_d      = fidx_q;
    fcol_d      = fcol_q;
    frow_d      = frow_q;
    lcol_d      = lcol_q;
    lrow_d      = lrow_q;
    res_d       = res_q;
    cx_d        = cx_q;
    dep_d       = dep_q;
    rd_vld_d    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    ra0_we      = 1'b0;
    ra1_we      = 1'b0;
    rar_we      = 1'b0;
    rar_wdata   = '0;

    // register writes
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COLUMNS: cols_d    = cfg_data_i[COLS_W-1:0];
        CFG_ROWS:    rows_d    = cfg_data_i[ROWS_W-1:0];
        CFG_SPACING: spacing_d = cfg_data_i[SPACING_W-1:0];
        CFG_GRIDS:   gpa_d     = cfg_data_i[GPA_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          kind_d    = in_i.kind;
          robot_d   = in_i.robot_no;
          covered_d = in_i.grids_done;
          state_d   = ST_COUNT;
        end
      end

      // area count, capped
      ST_COUNT: begin
        mul_a = MW'(cols_q);
        mul_b = SPACING_W'(rows_q);
        n_d   = (mul_p > PW'(MAX_AREAS)) ? AW'(MAX_AREAS) : AW'(mul_p);
        state_d = ST_GRID;
      end

      // total grid count
      ST_GRID: begin
        mul_a   = MW'(n_q);
        mul_b   = SPACING_W'(gpa_q);
        grid_d  = mul_p[TOT_W-1:0];
        state_d = ST_UPDATE;
      end

      // store the reported count in the robot's current area
      ST_UPDATE: begin
        if (kind_q == KIND_REPORT && robot_ok && ra_cur != '0 && ra_cur <= n_q) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(ra_cur - AW'(1));
        end
        s_d     = '0;
        sum_d   = '0;
        col_d   = '0;
        row_d   = '0;
        found_d = 1'b0;
        fidx_d  = '0;
        fcol_d  = '0;
        frow_d  = '0;
        lcol_d  = '0;
        lrow_d  = '0;
        state_d = ST_SCAN;
      end

      // one read issued and one entry summed per cycle
      ST_SCAN: begin
        if (s_q < n_q) begin
          ram_re    = 1'b1;
          ram_raddr = s_q[IW-1:0];
          rd_vld_d  = cov_vld_q[s_q[IW-1:0]];
        end
        if (s_q != '0) begin
          sum_d = sum_q + TOT_W'(scan_val);
          if (scan_val == '0 && !found_q) begin
            found_d = 1'b1;
            fidx_d  = IW'(s_q - AW'(1));
            fcol_d  = col_q;
            frow_d  = row_q;
          end
          lcol_d = col_q;
          lrow_d = row_q;
          if ((8'(col_q) + 8'd1) == 8'(cols_q)) begin
            col_d = '0;
            row_d = row_q + IW'(1);
          end else begin
            col_d = col_q + COLS_W'(1);
          end
        end
        if (s_q == n_q) begin
          res_d   = 1'b0;
          state_d = ST_CX;
          if (kind_q == KIND_START) begin
            if (n_q == '0) begin
              dep_d = '0;
            end else if (n_q > AW'(1)) begin
              ra0_we = 1'b1;
              ra1_we = 1'b1;
              dep_d  = DEP_W'(2);
            end else begin
              ra0_we = 1'b1;
              dep_d  = DEP_W'(1);
            end
          end else if (found_d && robot_ok) begin
            rar_we    = 1'b1;
            rar_wdata = AW'(fidx_d) + AW'(1);
          end
        end else begin
          s_d = s_q + AW'(1);
        end
      end

      // centre x of the selected area
      ST_CX: begin
        mul_a   = MW'(sel_col);
        mul_b   = spacing_q;
        cx_d    = CTR_W'(mul_p + PW'(spacing_q >> 1));
        state_d = ST_CY;
      end

      // centre y, then load the output word once the register is free
      ST_CY: begin
        mul_a = MW'(sel_row);
        mul_b = spacing_q;
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.target_robot    = sel_robot;
          out_d.assigned        = sel_ok;
          out_d.area_id         = sel_ok ? ID_W'(32'(sel_idx) + 32'd1) : '0;
          out_d.centre_x        = sel_ok ? cx_q : '0;
          out_d.centre_y        = sel_ok ? CTR_W'(mul_p + PW'(spacing_q >> 1)) : '0;
          out_d.covered_total   = sum_q;
          out_d.grid_total      = grid_q;
          out_d.robots_deployed = dep_q;
          out_d.last            = sel_last;
          if (sel_last) begin
            state_d = ST_IDLE;
          end else begin
            res_d   = 1'b1;
            state_d = ST_CX;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cols_q      <= RST_COLUMNS;
      rows_q      <= RST_ROWS;
      spacing_q   <= RST_SPACING;
      gpa_q       <= RST_GRIDS;
      n_q         <= '0;
      s_q         <= '0;
      found_q     <= 1'b0;
      res_q       <= 1'b0;
      dep_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cov_vld_q   <= '0;
      for (int r = 0; r < MAX_ROBOT_COUNT; r++) begin
        robot_area_q[r] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      spacing_q   <= spacing_d;
      gpa_q       <= gpa_d;
      n_q         <= n_d;
      s_q         <= s_d;
      found_q     <= found_d;
      res_q       <= res_d;
      dep_q       <= dep_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        cov_vld_q[ram_waddr] <= 1'b1;
      end
      if (ra0_we) begin
        robot_area_q[0] <= AW'(1);
      end
      if (ra1_we) begin
        robot_area_q[1] <= n_q;
      end
      if (rar_we) begin
        robot_area_q[robot_q[RW-1:0]] <= rar_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    robot_q   <= robot_d;
    covered_q <= covered_d;
    grid_q    <= grid_d;
    sum_q     <= sum_d;
    col_q     <= col_d;
    row_q     <= row_d;
    fidx_q    <= fidx_d;
    fcol_q    <= fcol_d;
    frow_q    <= frow_d;
    lcol_q    <= lcol_d;
    lrow_q    <= lrow_d;
    cx_q      <= cx_d;
    out_q     <= out_d;
  end

  // channel ports
  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.target_robot    = out_q.target_robot;
  assign out_o.assigned        = out_q.assigned;
  assign out_o.area_id         = out_q.area_id;
  assign out_o.centre_x        = out_q.centre_x;
  assign out_o.centre_y        = out_q.centre_y;
  assign out_o.covered_total   = out_q.covered_total;
  assign out_o.grid_total      = out_q.grid_total;
  assign out_o.robots_deployed = out_q.robots_deployed;
  assign out_o.last            = out_q.last;

  // terms for the checks below
  assign out_no_area   = (out_q.area_id == '0) && (out_q.centre_x == '0) &&
                         (out_q.centre_y == '0);
  assign out_pair_head = (out_q.target_robot == '0) && out_q.assigned;

  // checks
  `CAA_ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready, "ready after accept")
  `CAA_ASSERT_IMPL(a_scan_bound, state_q == ST_SCAN, s_q <= n_q, "scan ran past area count")
  `CAA_ASSERT_IMPL(a_unassigned_clear, out_o.valid && !out_o.assigned, out_no_area, "stray area")
  `CAA_ASSERT_IMPL(a_first_of_pair, out_o.valid && !out_o.last, out_pair_head, "bad first word")

endmodule

### bench/coverage_area_assigner_test.sv
// Self-checking bench for the coverage area assigner: directed and random requests,
// a scoreboard class that tracks the area table and robot assignments.
// Depends on caa_pkg, caa_in_if, caa_out_if and coverage_area_assigner.
`timescale 1ns / 1ps

module coverage_area_assigner_test import caa_pkg::*; ();
  localparam int TOTAL_ITEMS  = 1350;
  localparam int CALM_ITEMS   = 150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RIDX_W       = $clog2(DEF_MAX_ROBOTS);

  // Tracks the coverage table, robot assignments and registers; holds due words
  class assigner_scoreboard;
    logic [COV_W-1:0]      area_cover [DEF_MAX_AREAS];
    logic [ID_W-1:0]       robot_area [DEF_MAX_ROBOTS];
    logic [DEP_W-1:0]      deployed;
    logic [COLS_W-1:0]     columns;
    logic [ROWS_W-1:0]     rows;
    logic [SPACING_W-1:0]  spacing;
    logic [GPA_W-1:0]      grids;
    result_t               due_words [$];
    int                    errors;
    int                    words_checked;
    int                    unassigned_words;

    function new();
      foreach (area_cover[i]) area_cover[i] = '0;
      foreach (robot_area[i]) robot_area[i] = '0;
      deployed         = '0;
      columns          = RST_COLUMNS;
      rows             = RST_ROWS;
      spacing          = RST_SPACING;
      grids            = RST_GRIDS;
      errors           = 0;
      words_checked    = 0;
      unassigned_words = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COLUMNS: columns = data[COLS_W-1:0];
        CFG_ROWS:    rows    = data[ROWS_W-1:0];
        CFG_SPACING: spacing = data[SPACING_W-1:0];
        CFG_GRIDS:   grids   = data[GPA_W-1:0];
        default: ;
      endcase
    endfunction

    // columns * rows, capped at the table size
    function int unsigned area_count();
      int unsigned c, r, n;
      c = 32'(columns);
      r = 32'(rows);
      n = c * r;
      return (n > DEF_MAX_AREAS) ? DEF_MAX_AREAS : n;
    endfunction

    // One result word from the current state
    function result_t make_word(logic [ROBOT_W-1:0] robot, int unsigned idx, bit ok,
                                bit fin);
      int unsigned n, sum, c, s, cx, cy, g;
      result_t w;
      n   = area_count();
      sum = 0;
      c   = 32'(columns);
      s   = 32'(spacing);
      g   = 32'(grids);
      for (int unsigned i = 0; i < n; i++) sum += 32'(area_cover[i]);
      w.target_robot = robot;
      w.assigned     = ok;
      if (ok && c != 0) begin
        cx         = (idx % c) * s + s / 2;
        cy         = (idx / c) * s + s / 2;
        w.area_id  = ID_W'(idx + 1);
        w.centre_x = CTR_W'(cx);
        w.centre_y = CTR_W'(cy);
      end else begin
        w.area_id  = '0;
        w.centre_x = '0;
        w.centre_y = '0;
      end
      w.covered_total   = TOT_W'(sum);
      w.grid_total      = TOT_W'(n * g);
      w.robots_deployed = deployed;
      w.last            = fin;
      return w;
    endfunction

    // Accepted request: update state, queue the words it gives
    function void note_request(logic kind, logic [ROBOT_W-1:0] robot,
                               logic [COV_W-1:0] covered);
      int unsigned n, a, i;
      n = area_count();
      if (kind == KIND_START) begin
        if (n == 0) begin
          deployed = 2'd0;
          due_words.push_back(make_word('0, 0, 1'b0, 1'b1));
        end else begin
          robot_area[0] = ID_W'(1);
          if (n > 1) begin
            robot_area[1] = ID_W'(n);
            deployed      = 2'd2;
            due_words.push_back(make_word(ROBOT_W'(0), 0, 1'b1, 1'b0));
            due_words.push_back(make_word(ROBOT_W'(1), n - 1, 1'b1, 1'b1));
          end else begin
            deployed = 2'd1;
            due_words.push_back(make_word(ROBOT_W'(0), 0, 1'b1, 1'b1));
          end
        end
        return;
      end
      // stale, missing or out-of-table assignments leave the table alone
      if (32'(robot) < DEF_MAX_ROBOTS) begin
        a = 32'(robot_area[robot[RIDX_W-1:0]]);
        if (a >= 1 && a <= n) area_cover[a-1] = covered;
      end
      i = 0;
      while (i < n && area_cover[i] != 0) i++;
      if (i < n) begin
        if (32'(robot) < DEF_MAX_ROBOTS) robot_area[robot[RIDX_W-1:0]] = ID_W'(i + 1);
        due_words.push_back(make_word(robot, i, 1'b1, 1'b1));
      end else begin
        due_words.push_back(make_word(robot, 0, 1'b0, 1'b1));
      end
    endfunction

    function void cmp(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Accepted result word against the oldest due word
    function void check_word(result_t got);
      result_t want;
      if (due_words.size() == 0) begin
        $error("result word for robot %0d with nothing outstanding", got.target_robot);
        errors++;
        return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (!want.assigned) unassigned_words++;
      cmp("target_robot", 16'(want.target_robot), 16'(got.target_robot));
      cmp("assigned", 16'(want.assigned), 16'(got.assigned));
      cmp("area_id", 16'(want.area_id), 16'(got.area_id));
      cmp("centre_x", want.centre_x, got.centre_x);
      cmp("centre_y", want.centre_y, got.centre_y);
      cmp("covered_total", 16'(want.covered_total), 16'(got.covered_total));
      cmp("grid_total", 16'(want.grid_total), 16'(got.grid_total));
      cmp("robots_deployed", 16'(want.robots_deployed), 16'(got.robots_deployed));
      cmp("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  caa_in_if  req_if ();
  caa_out_if res_if ();

  assigner_scoreboard sb;
  int      gap_pct;
  int      sink_pct;
  int      items;
  int      settings;
  int      cycles;
  result_t seen_word;

  coverage_area_assigner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.due_words.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen_word.target_robot    = res_if.target_robot;
      seen_word.assigned        = res_if.assigned;
      seen_word.area_id         = res_if.area_id;
      seen_word.centre_x        = res_if.centre_x;
      seen_word.centre_y        = res_if.centre_y;
      seen_word.covered_total   = res_if.covered_total;
      seen_word.grid_total      = res_if.grid_total;
      seen_word.robots_deployed = res_if.robots_deployed;
      seen_word.last            = res_if.last;
      sb.check_word(seen_word);
    end
  end

  // Receiver: random stall bursts while sink_pct is non-zero
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // One request word; valid stays high on return so back-to-back words need no toggle
  task automatic send_request(logic kind, logic [ROBOT_W-1:0] robot, logic [COV_W-1:0] cov);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.robot_no   <= robot;
    req_if.grids_done <= cov;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(kind, robot, cov);
    items++;
  endtask

  // Hold off until every due word has come and the block is idle
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_words.size() != 0 || !req_if.ready || res_if.valid) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only while idle
  task automatic load_setting(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rws,
                              logic [CFG_DATA_W-1:0] spc, logic [CFG_DATA_W-1:0] gpa);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_COLUMNS;
    cfg_data <= cols;
    @(posedge clk_i);
    sb.write_reg(CFG_COLUMNS, cols);
    cfg_idx  <= CFG_ROWS;
    cfg_data <= rws;
    @(posedge clk_i);
    sb.write_reg(CFG_ROWS, rws);
    cfg_idx  <= CFG_SPACING;
    cfg_data <= spc;
    @(posedge clk_i);
    sb.write_reg(CFG_SPACING, spc);
    cfg_idx  <= CFG_GRIDS;
    cfg_data <= gpa;
    @(posedge clk_i);
    sb.write_reg(CFG_GRIDS, gpa);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  // Random register setting, mostly small grids; junk in unused data bits
  task automatic pick_setting();
    int unsigned sel, cols, rws, spc, gpa;
    logic [CFG_DATA_W-1:0] junk;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      cols = 0;
      rws  = $urandom_range(0, 64);
    end else if (sel == 1) begin
      cols = $urandom_range(1, 64);
      rws  = 0;
    end else if (sel == 2) begin
      cols = 64;
      rws  = 64;
    end else if (sel == 3) begin
      cols = $urandom_range(1, 127);
      rws  = $urandom_range(1, 127);
    end else if (sel == 4) begin
      cols = 1;
      rws  = 1;
    end else if (sel <= 7) begin
      cols = $urandom_range(1, 16);
      rws  = $urandom_range(1, 8);
    end else begin
      cols = $urandom_range(1, 4);
      rws  = $urandom_range(1, 4);
    end
    sel = $urandom_range(0, 9);
    spc = (sel == 0) ? 1 : (sel == 1) ? 1023 : (sel == 2) ? 0 : $urandom_range(1, 1023);
    sel = $urandom_range(0, 9);
    gpa = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(0, 255);
    junk = CFG_DATA_W'($urandom);
    load_setting({junk[9:7], 7'(cols)}, {junk[6:4], 7'(rws)}, CFG_DATA_W'(spc),
                 {junk[3:2], 8'(gpa)});
  endtask

  // One random request: mostly reports from deployed-range robots
  task automatic random_request();
    int unsigned p;
    logic [COV_W-1:0] cov;
    p   = $urandom_range(0, 99);
    cov = ($urandom_range(0, 99) < 15) ? '0 : COV_W'($urandom_range(1, 255));
    if (p < 5)
      send_request(KIND_START, ROBOT_W'($urandom), COV_W'($urandom));
    else if (p < 15)
      send_request(KIND_REPORT, ROBOT_W'($urandom), COV_W'($urandom));
    else if (p < 35)
      send_request(KIND_REPORT, ROBOT_W'($urandom_range(0, 15)), cov);
    else
      send_request(KIND_REPORT, ROBOT_W'($urandom_range(0, 3)), cov);
  endtask

  // Main sequence
  initial begin
    int phase_len;
    sb = new();
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= KIND_START;
    req_if.robot_no   <= '0;
    req_if.grids_done <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_COLUMNS;
    cfg_data          <= '0;
    gap_pct  = 25;
    sink_pct = 25;
    items    = 0;
    settings = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset grid, reports before any deployment, out-of-table robots
    send_request(KIND_REPORT, 8'd0, 8'hFF);
    send_request(KIND_REPORT, 8'hFF, 8'h00);
    send_request(KIND_START, 8'hA5, 8'h5A);
    send_request(KIND_REPORT, 8'd0, 8'd255);
    send_request(KIND_REPORT, 8'd1, 8'd1);
    send_request(KIND_REPORT, 8'd1, 8'd0);
    send_request(KIND_REPORT, 8'd15, 8'h80);
    send_request(KIND_REPORT, 8'd16, 8'd7);
    // single area: one deployment word
    drain_results();
    load_setting(10'd1, 10'd1, 10'd1, 10'd0);
    send_request(KIND_START, 8'd0, 8'd0);
    send_request(KIND_REPORT, 8'd0, 8'd5);
    // no areas at all
    drain_results();
    load_setting(10'd0, 10'd4, 10'd100, 10'd4);
    send_request(KIND_START, 8'd3, 8'd3);
    send_request(KIND_REPORT, 8'd0, 8'd9);
    // largest grid, widest spacing
    drain_results();
    load_setting(10'd64, 10'd64, 10'd1023, 10'd255);
    send_request(KIND_START, 8'd0, 8'd0);
    send_request(KIND_REPORT, 8'd1, 8'd200);
    send_request(KIND_REPORT, 8'd0, 8'd0);
    // two areas: stale assignment of robot 1, then run out of free areas
    drain_results();
    load_setting(10'd2, 10'd1, 10'd1, 10'd8);
    send_request(KIND_REPORT, 8'd1, 8'd3);
    send_request(KIND_START, 8'd0, 8'd0);
    send_request(KIND_REPORT, 8'd0, 8'd3);
    send_request(KIND_REPORT, 8'd1, 8'd9);
    send_request(KIND_REPORT, 8'd2, 8'd4);

    // Random phases, each under its own setting and idling mix; the calm
    // tail stays in the phase it starts in
    while (items < TOTAL_ITEMS) begin
      drain_results();
      pick_setting();
      gap_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      sink_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      phase_len = $urandom_range(15, 60);
      if ($urandom_range(0, 3) != 0)
        send_request(KIND_START, ROBOT_W'($urandom), COV_W'($urandom));
      for (int k = 0; (k < phase_len || items >= TOTAL_ITEMS - CALM_ITEMS) &&
                      items < TOTAL_ITEMS; k++) begin
        if (items >= TOTAL_ITEMS - CALM_ITEMS) begin
          gap_pct  = 0;
          sink_pct = 0;
        end
        random_request();
        if (items < TOTAL_ITEMS - CALM_ITEMS && $urandom_range(0, 49) == 0) drain_results();
      end
    end

    // Wind down
    req_if.valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests over %0d register settings; %0d result words checked",
             items, settings, sb.words_checked);
    $display("%0d words found no free area, %0d errors", sb.unassigned_words, sb.errors);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
